/* design/vsnc_pkg.sv */
`timescale 1ns / 1ps

package vsnc_pkg;

  // Cosine format: Q2.14 in a 16-bit signed word
  localparam int unsigned CosW    = 16;
  localparam int unsigned CosFrac = 14;

  // Quotient bits produced by the divide chain (one saturation bit plus 15 bits)
  localparam int unsigned QuotW   = CosFrac + 2;

  localparam logic [CosW-1:0] CosOne = CosW'(1) << CosFrac;

endpackage

/* design/vsnc_sqrt_cell.sv */
`timescale 1ns / 1ps

// One digit of a restoring square root: pulls in two radicand bits and
// settles one root bit per cycle while en_i is high.
module vsnc_sqrt_cell #(
  parameter int unsigned RootW = 25
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [RootW:0]     rem_i,
  input  logic [RootW-1:0]   root_i,
  output logic [2*RootW-1:0] rad_o,
  output logic [RootW:0]     rem_o,
  output logic [RootW-1:0]   root_o
);

  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] diff;
  logic             ge;

  logic [2*RootW-1:0] rad_d, rad_q;
  logic [RootW:0]     rem_d, rem_q;
  logic [RootW-1:0]   root_d, root_q;

  // Trial subtract of (root << 2) | 1 from the shifted remainder
  always_comb begin
    rem_sh = {rem_i, rad_i[2*RootW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    rem_d  = ge ? diff[RootW:0] : rem_sh[RootW:0];
    root_d = {root_i[RootW-2:0], ge};
    rad_d  = {rad_i[2*RootW-3:0], 2'b00};
  end

  // Advance the digit state
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* design/vsnc_div_cell.sv */
`timescale 1ns / 1ps

// One bit of a restoring divide: compares the partial remainder against
// the divisor shifted by Shift and appends one quotient bit.
module vsnc_div_cell #(
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 48,
  parameter int unsigned Shift = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NumW-1:0]              num_i,
  input  logic [DenW-1:0]              den_i,
  input  logic [vsnc_pkg::QuotW-1:0]   quot_i,
  output logic [NumW-1:0]              num_o,
  output logic [DenW-1:0]              den_o,
  output logic [vsnc_pkg::QuotW-1:0]   quot_o
);

  logic [NumW-1:0]            den_sh;
  logic                       ge;
  logic [NumW-1:0]            num_d, num_q;
  logic [DenW-1:0]            den_q;
  logic [vsnc_pkg::QuotW-1:0] quot_d, quot_q;

  // Compare and conditionally subtract the shifted divisor
  always_comb begin
    den_sh = NumW'(den_i) << Shift;
    ge     = (num_i >= den_sh);
    num_d  = ge ? (num_i - den_sh) : num_i;
    quot_d = {quot_i[vsnc_pkg::QuotW-2:0], ge};
  end

  // Hold or advance the partial result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= den_i;
      quot_q <= quot_d;
    end
  end

  assign num_o  = num_q;
  assign den_o  = den_q;
  assign quot_o = quot_q;

endmodule

/* design/vector2d_sum_norm_cosine.sv */
`timescale 1ns / 1ps

// Pipeline: products, radicands, the square root chain (one root bit per cell), the
// denominator product, the 16-cell divide chain and the output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result stalls.
// Reset: rst_ni clears the valid bits of all stages; data registers are not reset.
module vector2d_sum_norm_cosine #(
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned FRACTION_BITS  = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      stall_o,
  input  logic signed [COMPONENT_BITS-1:0]          first_x_i,
  input  logic signed [COMPONENT_BITS-1:0]          first_y_i,
  input  logic signed [COMPONENT_BITS-1:0]          second_x_i,
  input  logic signed [COMPONENT_BITS-1:0]          second_y_i,
  output logic                                      valid_o,
  input  logic                                      stall_i,
  output logic signed [COMPONENT_BITS:0]            sum_x_o,
  output logic signed [COMPONENT_BITS:0]            sum_y_o,
  output logic [COMPONENT_BITS+FRACTION_BITS:0]     sum_length_o,
  output logic [COMPONENT_BITS+FRACTION_BITS-1:0]   first_length_o,
  output logic [COMPONENT_BITS+FRACTION_BITS-1:0]   second_length_o,
  output logic signed [vsnc_pkg::CosW-1:0]          cosine_o,
  output logic                                      cosine_invalid_o
);

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned SW    = CB + 1;
  localparam int unsigned RB    = CB + 1 + FB;
  localparam int unsigned VW    = CB + FB;
  localparam int unsigned RADW  = 2 * RB;
  localparam int unsigned DENW  = 2 * VW;
  localparam int unsigned NUMW  = 2 * CB + 2 * FB + vsnc_pkg::CosFrac + 2;
  localparam int unsigned QW    = vsnc_pkg::QuotW;
  localparam int unsigned DSTG  = QW;
  localparam int unsigned NSTG  = RB + DSTG + 4;
  localparam int unsigned P1W   = 2 * SW + 2 * CB + 1;
  localparam int unsigned P2W   = 2 * SW + RB + 2 * VW + 2;

  // Global advance: hold everything while the output transaction stalls
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en      = !(vld_q[NSTG-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  // Stage 1: products and component sums
  logic [2*CB-1:0]        fx2_q, fy2_q, sx2_q, sy2_q;
  logic [2*SW-1:0]        cx2_q, cy2_q;
  logic signed [2*CB-1:0] d1_q, d2_q;
  logic signed [SW-1:0]   cx_q, cy_q;
  logic signed [SW-1:0]   cx_d, cy_d;
  logic signed [2*CB-1:0] fx2_s, fy2_s, sx2_s, sy2_s;
  logic signed [2*SW-1:0] cx2_s, cy2_s;

  always_comb begin
    cx_d  = SW'(first_x_i) + SW'(second_x_i);
    cy_d  = SW'(first_y_i) + SW'(second_y_i);
    fx2_s = first_x_i * first_x_i;
    fy2_s = first_y_i * first_y_i;
    sx2_s = second_x_i * second_x_i;
    sy2_s = second_y_i * second_y_i;
    cx2_s = cx_d * cx_d;
    cy2_s = cy_d * cy_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx2_q <= fx2_s;
      fy2_q <= fy2_s;
      sx2_q <= sx2_s;
      sy2_q <= sy2_s;
      cx2_q <= cx2_s;
      cy2_q <= cy2_s;
      d1_q  <= first_x_i * second_x_i;
      d2_q  <= first_y_i * second_y_i;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
    end
  end

  // Stage 2: radicands and dot product magnitude
  logic [RADW-1:0]        rad_w [3][RB+1];
  logic [RB:0]            rem_w [3][RB+1];
  logic [RB-1:0]          root_w[3][RB+1];
  logic [P1W-1:0]         p1_q  [RB+1];
  logic signed [2*CB:0]   dot_s;
  logic [2*CB:0]          dot_abs;

  always_comb begin
    dot_s   = (2*CB+1)'(d1_q) + (2*CB+1)'(d2_q);
    dot_abs = dot_s[2*CB] ? -dot_s : dot_s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_w[0][0] <= RADW'((2*SW+1)'(cx2_q) + (2*SW+1)'(cy2_q)) << (2 * FB);
      rad_w[1][0] <= RADW'((2*CB+1)'(fx2_q) + (2*CB+1)'(fy2_q)) << (2 * FB);
      rad_w[2][0] <= RADW'((2*CB+1)'(sx2_q) + (2*CB+1)'(sy2_q)) << (2 * FB);
      p1_q[0]     <= {cx_q, cy_q, dot_abs[2*CB-1:0], dot_s[2*CB]};
    end
  end

  // Square root chains: sum, first and second vector
  genvar gj, gi;
  generate
    for (gj = 0; gj < 3; gj++) begin : g_root
      assign rem_w[gj][0]  = '0;
      assign root_w[gj][0] = '0;
      for (gi = 0; gi < RB; gi++) begin : g_cell
        vsnc_sqrt_cell #(
          .RootW(RB)
        ) u_cell (
          .clk_i  (clk_i),
          .en_i   (en),
          .rad_i  (rad_w[gj][gi]),
          .rem_i  (rem_w[gj][gi]),
          .root_i (root_w[gj][gi]),
          .rad_o  (rad_w[gj][gi+1]),
          .rem_o  (rem_w[gj][gi+1]),
          .root_o (root_w[gj][gi+1])
        );
      end
    end
    for (gi = 0; gi < RB; gi++) begin : g_p1
      always_ff @(posedge clk_i) begin
        if (en) begin
          p1_q[gi+1] <= p1_q[gi];
        end
      end
    end
  endgenerate

  // Denominator product and numerator alignment
  logic [NUMW-1:0]     num_w [DSTG+1];
  logic [DENW-1:0]     den_w [DSTG+1];
  logic [QW-1:0]       quot_w[DSTG+1];
  logic [P2W-1:0]      p2_q  [DSTG+1];
  logic [VW-1:0]       len_a, len_b;
  logic [2*CB-1:0]     dmag;

  assign len_a = root_w[1][RB][VW-1:0];
  assign len_b = root_w[2][RB][VW-1:0];
  assign dmag  = p1_q[RB][2*CB:1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_w[0] <= len_a * len_b;
      num_w[0] <= NUMW'(dmag) << (vsnc_pkg::CosFrac + 2 * FB);
      p2_q[0]  <= {p1_q[RB][P1W-1 -: 2*SW], root_w[0][RB], len_a, len_b,
                   p1_q[RB][0], (len_a == '0) || (len_b == '0)};
    end
  end

  assign quot_w[0] = '0;

  // Divide chain: saturation bit first, then the fraction bits
  generate
    for (gi = 0; gi < DSTG; gi++) begin : g_div
      vsnc_div_cell #(
        .NumW (NUMW),
        .DenW (DENW),
        .Shift(DSTG - 1 - gi)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .num_i  (num_w[gi]),
        .den_i  (den_w[gi]),
        .quot_i (quot_w[gi]),
        .num_o  (num_w[gi+1]),
        .den_o  (den_w[gi+1]),
        .quot_o (quot_w[gi+1])
      );
      always_ff @(posedge clk_i) begin
        if (en) begin
          p2_q[gi+1] <= p2_q[gi];
        end
      end
    end
  endgenerate

  // Clamp, apply sign and register the result
  logic [P2W-1:0]               pf;
  logic [QW-1:0]                qv;
  logic [vsnc_pkg::CosW-1:0]    cmag;
  logic [vsnc_pkg::CosW-1:0]    cos_d;

  assign pf = p2_q[DSTG];
  assign qv = quot_w[DSTG];

  always_comb begin
    if (qv[QW-1] || (vsnc_pkg::CosW'(qv[QW-2:0]) > vsnc_pkg::CosOne)) begin
      cmag = vsnc_pkg::CosOne;
    end else begin
      cmag = vsnc_pkg::CosW'(qv[QW-2:0]);
    end
    if (pf[0]) begin
      cos_d = '0;
    end else if (pf[1]) begin
      cos_d = -cmag;
    end else begin
      cos_d = cmag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_x_o          <= pf[P2W-1 -: SW];
      sum_y_o          <= pf[P2W-SW-1 -: SW];
      sum_length_o     <= pf[2*VW+RB+1 -: RB];
      first_length_o   <= pf[2*VW+1 -: VW];
      second_length_o  <= pf[VW+1 -: VW];
      cosine_o         <= cos_d;
      cosine_invalid_o <= pf[0];
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CB = 16;
  localparam int unsigned FB = 8;
  localparam int unsigned LATENCY = CB + FB + 21;
  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CB:0]                   sum_x;
    logic signed [CB:0]                   sum_y;
    logic [CB+FB:0]                       sum_length;
    logic [CB+FB-1:0]                     first_length;
    logic [CB+FB-1:0]                     second_length;
    logic signed [vsnc_pkg::CosW-1:0]     cosine;
    logic                                 cosine_invalid;
  } vec_result_t;

  // Predicts the per-pair result and checks the output stream in order.
  class vector_scoreboard;
    vec_result_t pending[$];
    int unsigned mismatches;

    // floor(sqrt(v)) by bitwise search
    function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0]  root;
      logic [63:0]  cand;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if ({64'd0, cand} * {64'd0, cand} <= v) root = cand;
      end
      return root;
    endfunction

    function automatic logic [63:0] fixed_len(longint x, longint y);
      logic [127:0] sq;
      sq = 128'(x * x + y * y) << (2 * FB);
      return isqrt(sq);
    endfunction

    function void note_pair(logic signed [CB-1:0] fx, logic signed [CB-1:0] fy,
                            logic signed [CB-1:0] sx, logic signed [CB-1:0] sy);
      vec_result_t  r;
      longint       cx, cy, dot;
      logic [63:0]  la, lb, ls;
      logic [127:0] num, den, q;
      cx = longint'(fx) + longint'(sx);
      cy = longint'(fy) + longint'(sy);
      ls = fixed_len(cx, cy);
      la = fixed_len(fx, fy);
      lb = fixed_len(sx, sy);
      dot = longint'(fx) * longint'(sx) + longint'(fy) * longint'(sy);
      r.sum_x = cx[CB:0];
      r.sum_y = cy[CB:0];
      r.sum_length = ls[CB+FB:0];
      r.first_length = la[CB+FB-1:0];
      r.second_length = lb[CB+FB-1:0];
      r.cosine_invalid = (la == 0) || (lb == 0);
      r.cosine = '0;
      if (!r.cosine_invalid) begin
        num = 128'(dot < 0 ? -dot : dot) << (vsnc_pkg::CosFrac + 2 * FB);
        den = {64'd0, la} * {64'd0, lb};
        q = num / den;
        if (q > 128'(vsnc_pkg::CosOne)) q = 128'(vsnc_pkg::CosOne);
        r.cosine = (dot < 0) ? -vsnc_pkg::CosW'(q) : vsnc_pkg::CosW'(q);
      end
      pending.push_back(r);
    endfunction

    function void check_result(vec_result_t got);
      vec_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp sx=%0d sy=%0d sl=%0d fl=%0d dl=%0d c=%0d i=%0b",
                   exp_r.sum_x, exp_r.sum_y, exp_r.sum_length, exp_r.first_length,
                   exp_r.second_length, exp_r.cosine, exp_r.cosine_invalid);
          $display("          got sx=%0d sy=%0d sl=%0d fl=%0d dl=%0d c=%0d i=%0b",
                   got.sum_x, got.sum_y, got.sum_length, got.first_length,
                   got.second_length, got.cosine, got.cosine_invalid);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [CB-1:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic stall_o, valid_o, cosine_invalid_o;
  logic signed [CB:0] sum_x_o, sum_y_o;
  logic [CB+FB:0] sum_length_o;
  logic [CB+FB-1:0] first_length_o, second_length_o;
  logic signed [vsnc_pkg::CosW-1:0] cosine_o;

  vector_scoreboard sb = new();
  bit calm = 1'b0;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vector2d_sum_norm_cosine #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) uut (.*);

  // Check results and note accepted pairs; drive the result stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i)
        sb.check_result('{sum_x_o, sum_y_o, sum_length_o, first_length_o,
                          second_length_o, cosine_o, cosine_invalid_o});
      if (valid_i && !stall_o) sb.note_pair(first_x_i, first_y_i, second_x_i, second_y_i);
      if ((valid_o && !stall_i) || (valid_i && !stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      stall_i <= calm ? 1'b0 : ($urandom_range(99) < 16);
    end
  end

  // Hold the watchdog.
  always @(posedge clk_i) begin
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[vector2d_sum_norm_cosine] ERROR");
      $finish;
    end
  end

  function automatic logic [CB-1:0] pick_component();
    case ($urandom_range(5))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return '0;
      3: return CB'($signed($urandom_range(8)) - 4);
      default: return CB'($urandom);
    endcase
  endfunction

  // Present one pair and hold it until accepted.
  task automatic send_pair(logic [CB-1:0] fx, logic [CB-1:0] fy,
                           logic [CB-1:0] sx, logic [CB-1:0] sy);
    while (!calm && $urandom_range(99) < 16) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    first_x_i <= fx;
    first_y_i <= fy;
    second_x_i <= sx;
    second_y_i <= sy;
    do @(posedge clk_i); while (stall_o);
  endtask

  initial begin
    logic [CB-1:0] mn, mx;
    mn = {1'b1, {(CB-1){1'b0}}};
    mx = {1'b0, {(CB-1){1'b1}}};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: zero vectors, extremes, parallel, opposite, orthogonal.
    send_pair(CB'(0), CB'(0), CB'(0), CB'(0));
    send_pair(CB'(0), CB'(0), CB'(5), CB'(7));
    send_pair(CB'(3), CB'(4), CB'(0), CB'(0));
    send_pair(mx, mx, mx, mx);
    send_pair(mn, mn, mn, mn);
    send_pair(mn, mn, mx, mx);
    send_pair(mx, mn, mn, mx);
    send_pair(mn, CB'(0), mn, CB'(0));
    send_pair(CB'(1), CB'(1), CB'(1), CB'(1));
    send_pair(CB'(1), CB'(0), CB'(-1), CB'(0));
    send_pair(CB'(1), CB'(0), CB'(0), CB'(1));
    send_pair(CB'(3), CB'(4), CB'(6), CB'(8));
    send_pair(CB'(3), CB'(4), CB'(-6), CB'(-8));
    send_pair(CB'(1), CB'(2), CB'(2), CB'(4));
    send_pair(CB'(-1), CB'(-1), CB'(1), CB'(1));
    send_pair(16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF);
    // Pause until the pipeline drains.
    valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 900);
      send_pair(pick_component(), pick_component(), pick_component(), pick_component());
    end
    calm = 1'b0;
    valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[vector2d_sum_norm_cosine] OK");
    end else begin
      $display("[vector2d_sum_norm_cosine] ERROR");
    end
    $finish;
  end
endmodule

/* vector2d_sum_norm_cosine.f */
design/vsnc_pkg.sv
design/vsnc_sqrt_cell.sv
design/vsnc_div_cell.sv
design/vector2d_sum_norm_cosine.sv
tb/sv/testbench.sv
